[hw/rtl/scf_pkg.sv]
// Shared constants, register map and controller/datapath command types
// for the sigma-clip sample filter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package scf_pkg;

   localparam int WORD_W           = 32;
   localparam int SCALE_W          = 16;
   localparam int REJ_W            = 6;
   localparam int SQRT_STEPS       = 16 * 2;
   localparam int MAX_SAMPLES_DEF  = 32;
   localparam int MIN_FOR_CLIP_DEF = 8;

   localparam logic [REJ_W-1:0]   REJ_MAX     = '1;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd768;
   localparam logic [WORD_W-1:0]  LIMIT_RESET = '0;

   localparam int CSR_ADDR_W = 3;
   localparam logic [0:0] CSR_SIGMA_SCALE     = 1'b0;
   localparam logic [0:0] CSR_VARIATION_LIMIT = 1'b1;

   typedef struct packed {
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] rad;
      logic [WORD_W-1:0] depth;
   } entry_type;

   typedef enum logic [1:0] {
      DIV_MEAN  = 2'd0,
      DIV_VAR   = 2'd1,
      DIV_RATIO = 2'd2
   } div_sel_type;

   typedef struct packed {
      logic        take;
      logic        start;
      logic        div_ld;
      div_sel_type div_sel;
      logic        div_step;
      logic        div_save;
      logic        rd_en;
      logic        sq_mul;
      logic        sq_acc;
      logic        sqrt_step;
      logic        ratio_sat;
      logic        thr_ld;
      logic        out_sample;
      logic        drop;
      logic        out_summary;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic mean_zero;
      logic idx_done;
      logic keep;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

[hw/rtl/scf_if.sv]
// Request and response stream interfaces of the sigma-clip sample filter.
// Depends on scf_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface scf_req_if;
   logic                       valid;
   logic                       ready;
   logic [scf_pkg::WORD_W-1:0] pos_x;
   logic [scf_pkg::WORD_W-1:0] pos_y;
   logic [scf_pkg::WORD_W-1:0] radiance;
   logic [scf_pkg::WORD_W-1:0] path_depth;
   logic                       invalid;
   logic                       last;

   modport source (output valid, pos_x, pos_y, radiance, path_depth, invalid, last,
                   input ready);
   modport sink (input valid, pos_x, pos_y, radiance, path_depth, invalid, last,
                 output ready);
endinterface

interface scf_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic [scf_pkg::WORD_W-1:0] out_x;
   logic [scf_pkg::WORD_W-1:0] out_y;
   logic [scf_pkg::WORD_W-1:0] out_radiance;
   logic [scf_pkg::WORD_W-1:0] out_depth;
   logic [scf_pkg::WORD_W-1:0] mean;
   logic [scf_pkg::WORD_W-1:0] deviation;
   logic [scf_pkg::WORD_W-1:0] variation;
   logic [scf_pkg::REJ_W-1:0]  rejected;
   logic                       needs_pass;
   logic                       end_of_pixel;

   modport source (output valid, kind, out_x, out_y, out_radiance, out_depth, mean,
                   deviation, variation, rejected, needs_pass, end_of_pixel,
                   input ready);
   modport sink (input valid, kind, out_x, out_y, out_radiance, out_depth, mean,
                 deviation, variation, rejected, needs_pass, end_of_pixel,
                 output ready);
endinterface
`default_nettype wire

[hw/rtl/scf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module scf_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

[hw/rtl/scf_dpath.sv]
// Datapath: sample store, accumulators, shared serial divider, square root,
// clip test and response register. Depends on scf_pkg, scf_if and scf_ram.
`timescale 1ns / 1ps
`default_nettype none
module scf_dpath #(
   parameter int MAX_SAMPLES  = scf_pkg::MAX_SAMPLES_DEF,
   parameter int MIN_FOR_CLIP = scf_pkg::MIN_FOR_CLIP_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  scf_pkg::cmd_type            cmd,
   output scf_pkg::status_type         status,
   input  logic [scf_pkg::WORD_W-1:0]  pos_x,
   input  logic [scf_pkg::WORD_W-1:0]  pos_y,
   input  logic [scf_pkg::WORD_W-1:0]  radiance,
   input  logic [scf_pkg::WORD_W-1:0]  path_depth,
   input  logic                        invalid,
   input  logic [scf_pkg::SCALE_W-1:0] sigma_scale,
   input  logic [scf_pkg::WORD_W-1:0]  variation_limit,
   scf_rsp_if.source                   rsp
);
   import scf_pkg::*;

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int ADDR_W = $clog2(MAX_SAMPLES);
   localparam int SUM_W  = WORD_W + CNT_W;
   localparam int DIV_W  = 2 * WORD_W + CNT_W;
   localparam int SR_W   = WORD_W + 2;
   localparam int THR_W  = WORD_W + SCALE_W;
   localparam int CMP_W  = 7;

   logic [CNT_W-1:0]    count_ff, idx_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [REJ_W-1:0]    rej_ff;
   logic [WORD_W-1:0]   mean_ff, dev_ff, var_ff;
   logic [DIV_W-1:0]    sqacc_ff, dvd_ff;
   logic [2*WORD_W-1:0] sq_ff, rad_ff;
   logic [WORD_W-1:0]   dsr_ff, rem_ff;
   logic [SR_W-1:0]     srem_ff;
   logic [THR_W-1:0]    thr_ff;
   logic                out_valid_ff;
   entry_type           wr_entry, rd_entry;
   logic                store_ok, rej_inc;
   logic [WORD_W-1:0]   diff;
   logic [WORD_W:0]     rem_t;
   logic                div_ge;
   logic [SR_W+1:0]     srem_t, trial;
   logic                sqrt_ge;
   logic                clip_en;

   assign store_ok = !invalid && (count_ff < CNT_W'(MAX_SAMPLES));
   assign wr_entry = '{x: pos_x, y: pos_y, rad: radiance, depth: path_depth};

   scf_ram #(.WIDTH($bits(entry_type)), .DEPTH(MAX_SAMPLES)) u_store (
      .clock      (clock),
      .wr_en      (cmd.take && store_ok),
      .wr_addr    (count_ff[ADDR_W-1:0]),
      .wr_data    (wr_entry),
      .rd_en      (cmd.rd_en),
      .rd_addr    (idx_ff[ADDR_W-1:0]),
      .rd_data_ff (rd_entry)
   );

   assign diff    = (rd_entry.rad >= mean_ff) ? rd_entry.rad - mean_ff
                                              : mean_ff - rd_entry.rad;
   assign rej_inc = (cmd.take && !store_ok) || cmd.drop;
   assign rem_t   = {rem_ff, dvd_ff[DIV_W-1]};
   assign div_ge  = rem_t >= {1'b0, dsr_ff};
   assign srem_t  = {srem_ff, rad_ff[2*WORD_W-1 -: 2]};
   assign trial   = {2'b00, dev_ff, 2'b01};
   assign sqrt_ge = srem_t >= trial;
   assign clip_en = (CMP_W'(count_ff) >= CMP_W'(MIN_FOR_CLIP)) && (sigma_scale != '0);

   assign status.n_zero    = count_ff == '0;
   assign status.mean_zero = mean_ff == '0;
   assign status.idx_done  = idx_ff == count_ff;
   assign status.keep      = !clip_en || (THR_W'({diff, 8'h00}) < thr_ff);
   assign status.out_free  = !out_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sum_ff       <= '0;
         rej_ff       <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_summary) begin
            count_ff <= '0;
            sum_ff   <= '0;
            rej_ff   <= '0;
         end else begin
            if (cmd.take && store_ok) begin
               count_ff <= count_ff + 1'b1;
               sum_ff   <= sum_ff + SUM_W'(radiance);
            end
            if (rej_inc && rej_ff != REJ_MAX) begin
               rej_ff <= rej_ff + 1'b1;
            end
         end
         if (cmd.start || cmd.thr_ld) begin
            idx_ff <= '0;
         end else if (cmd.sq_acc || cmd.out_sample || cmd.drop) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.out_sample || cmd.out_summary) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mean_ff  <= '0;
         dev_ff   <= '0;
         sqacc_ff <= '0;
      end
      if (cmd.div_ld) begin
         rem_ff <= '0;
         case (cmd.div_sel)
            DIV_MEAN: begin
               dvd_ff <= DIV_W'(sum_ff);
               dsr_ff <= WORD_W'(count_ff);
            end
            DIV_VAR: begin
               dvd_ff <= sqacc_ff;
               dsr_ff <= WORD_W'(count_ff);
            end
            default: begin
               dvd_ff <= DIV_W'({dev_ff, 16'h0000});
               dsr_ff <= mean_ff;
            end
         endcase
      end
      if (cmd.div_step) begin
         rem_ff <= div_ge ? rem_t[WORD_W-1:0] - dsr_ff : rem_t[WORD_W-1:0];
         dvd_ff <= {dvd_ff[DIV_W-2:0], div_ge};
      end
      if (cmd.div_save) begin
         case (cmd.div_sel)
            DIV_MEAN: mean_ff <= dvd_ff[WORD_W-1:0];
            DIV_VAR: begin
               rad_ff  <= dvd_ff[2*WORD_W-1:0];
               srem_ff <= '0;
               dev_ff  <= '0;
            end
            default: var_ff <= (|dvd_ff[DIV_W-1:WORD_W]) ? '1 : dvd_ff[WORD_W-1:0];
         endcase
      end
      if (cmd.ratio_sat) begin
         var_ff <= '1;
      end
      if (cmd.sqrt_step) begin
         srem_ff <= sqrt_ge ? SR_W'(srem_t - trial) : SR_W'(srem_t);
         dev_ff  <= {dev_ff[WORD_W-2:0], sqrt_ge};
         rad_ff  <= {rad_ff[2*WORD_W-3:0], 2'b00};
      end
      if (cmd.sq_mul) begin
         sq_ff <= diff * diff;
      end
      if (cmd.sq_acc) begin
         sqacc_ff <= sqacc_ff + DIV_W'(sq_ff);
      end
      if (cmd.thr_ld) begin
         thr_ff <= sigma_scale * dev_ff;
      end
      if (cmd.out_sample) begin
         rsp.kind         <= 1'b0;
         rsp.out_x        <= rd_entry.x;
         rsp.out_y        <= rd_entry.y;
         rsp.out_radiance <= rd_entry.rad;
         rsp.out_depth    <= rd_entry.depth;
         rsp.mean         <= '0;
         rsp.deviation    <= '0;
         rsp.variation    <= '0;
         rsp.rejected     <= '0;
         rsp.needs_pass   <= 1'b0;
         rsp.end_of_pixel <= 1'b0;
      end else if (cmd.out_summary) begin
         rsp.kind         <= 1'b1;
         rsp.out_x        <= '0;
         rsp.out_y        <= '0;
         rsp.out_radiance <= '0;
         rsp.out_depth    <= '0;
         rsp.mean         <= mean_ff;
         rsp.deviation    <= dev_ff;
         rsp.variation    <= var_ff;
         rsp.rejected     <= rej_ff;
         rsp.needs_pass   <= (variation_limit != '0) && (var_ff > variation_limit);
         rsp.end_of_pixel <= 1'b1;
      end
   end

   assign rsp.valid = out_valid_ff;
endmodule
`default_nettype wire

[hw/rtl/scf_ctrl.sv]
// Controller: sequences loading, mean, variance, square root, ratio,
// clip walk and summary. Depends on scf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scf_ctrl #(
   parameter int MAX_SAMPLES = scf_pkg::MAX_SAMPLES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_ready,
   input  scf_pkg::status_type status,
   output scf_pkg::cmd_type    cmd
);
   import scf_pkg::*;

   localparam int DIV_W = 2 * WORD_W + $clog2(MAX_SAMPLES + 1);
   localparam int ITER_W = $clog2(DIV_W);

   typedef enum logic [16:0] {
      S_IDLE       = 17'h00001,
      S_START      = 17'h00002,
      S_MEAN_DIV   = 17'h00004,
      S_MEAN_SAVE  = 17'h00008,
      S_SQ_RD      = 17'h00010,
      S_SQ_MUL     = 17'h00020,
      S_SQ_ACC     = 17'h00040,
      S_VAR_DIV    = 17'h00080,
      S_VAR_SAVE   = 17'h00100,
      S_SQRT       = 17'h00200,
      S_RATIO      = 17'h00400,
      S_RATIO_DIV  = 17'h00800,
      S_RATIO_SAVE = 17'h01000,
      S_THR        = 17'h02000,
      S_EM_RD      = 17'h04000,
      S_EM_CHK     = 17'h08000,
      S_SUMMARY    = 17'h10000
   } state_type;

   state_type         state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              div_end, sqrt_end;

   assign div_end  = iter_ff == ITER_W'(DIV_W - 1);
   assign sqrt_end = iter_ff == ITER_W'(SQRT_STEPS - 1);

   always_comb begin
      state_in  = state_ff;
      iter_in   = iter_ff + 1'b1;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (req_last) state_in = S_START;
            end
         end
         S_START: begin
            cmd.start   = 1'b1;
            iter_in     = '0;
            cmd.div_sel = DIV_MEAN;
            if (status.n_zero) begin
               state_in = S_RATIO;
            end else begin
               cmd.div_ld = 1'b1;
               state_in   = S_MEAN_DIV;
            end
         end
         S_MEAN_DIV: begin
            cmd.div_step = 1'b1;
            if (div_end) state_in = S_MEAN_SAVE;
         end
         S_MEAN_SAVE: begin
            cmd.div_save = 1'b1;
            cmd.div_sel  = DIV_MEAN;
            state_in     = S_SQ_RD;
         end
         S_SQ_RD: begin
            iter_in = '0;
            if (status.idx_done) begin
               cmd.div_ld  = 1'b1;
               cmd.div_sel = DIV_VAR;
               state_in    = S_VAR_DIV;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_SQ_MUL;
            end
         end
         S_SQ_MUL: begin
            cmd.sq_mul = 1'b1;
            state_in   = S_SQ_ACC;
         end
         S_SQ_ACC: begin
            cmd.sq_acc = 1'b1;
            state_in   = S_SQ_RD;
         end
         S_VAR_DIV: begin
            cmd.div_step = 1'b1;
            if (div_end) state_in = S_VAR_SAVE;
         end
         S_VAR_SAVE: begin
            cmd.div_save = 1'b1;
            cmd.div_sel  = DIV_VAR;
            iter_in      = '0;
            state_in     = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (sqrt_end) state_in = S_RATIO;
         end
         S_RATIO: begin
            iter_in     = '0;
            cmd.div_sel = DIV_RATIO;
            if (status.mean_zero) begin
               cmd.ratio_sat = 1'b1;
               state_in      = S_THR;
            end else begin
               cmd.div_ld = 1'b1;
               state_in   = S_RATIO_DIV;
            end
         end
         S_RATIO_DIV: begin
            cmd.div_step = 1'b1;
            if (div_end) state_in = S_RATIO_SAVE;
         end
         S_RATIO_SAVE: begin
            cmd.div_save = 1'b1;
            cmd.div_sel  = DIV_RATIO;
            state_in     = S_THR;
         end
         S_THR: begin
            cmd.thr_ld = 1'b1;
            state_in   = S_EM_RD;
         end
         S_EM_RD: begin
            if (status.idx_done) begin
               state_in = S_SUMMARY;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_EM_CHK;
            end
         end
         S_EM_CHK: begin
            if (!status.keep) begin
               cmd.drop = 1'b1;
               state_in = S_EM_RD;
            end else if (status.out_free) begin
               cmd.out_sample = 1'b1;
               state_in       = S_EM_RD;
            end
         end
         S_SUMMARY: begin
            if (status.out_free) begin
               cmd.out_summary = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end
endmodule
`default_nettype wire

[hw/rtl/sigma_clip_sample_filter.sv]
// Top level of the sigma-clip sample filter: configuration registers and
// controller/datapath wiring. Depends on scf_pkg, scf_if, scf_ctrl, scf_dpath.
`timescale 1ns / 1ps
`default_nettype none
// Requests of a pixel are taken while the filter is idle; each sample is
// written to the sample store unless it is invalid or the store is full, in
// which case it is counted as rejected. The request flagged last starts the
// pixel computation, during which no request is taken: a bit-serial divider
// computes the mean, the variance and the deviation-to-mean ratio, each with
// a load and a save step (the variance load is issued as the sum-of-squares
// walk ends); the sum of squares walks the store through one 32x32 multiplier,
// reading, squaring and accumulating each sample in turn; the square root is
// found bit-serially; the clip walk reads and tests each stored sample, then
// the summary is sent, an output waiting while the response side stalls. A
// zero mean skips the ratio division. Registers: sigma_scale at byte address
// 0, variation_limit at 4.
module sigma_clip_sample_filter #(
   parameter int MAX_SAMPLES  = scf_pkg::MAX_SAMPLES_DEF,
   parameter int MIN_FOR_CLIP = scf_pkg::MIN_FOR_CLIP_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   scf_req_if.sink                        req_ch,
   scf_rsp_if.source                      rsp_ch,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [scf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [scf_pkg::WORD_W-1:0]     csr_pwdata,
   output logic [scf_pkg::WORD_W-1:0]     csr_prdata,
   output logic                           csr_pready
);
   import scf_pkg::*;

   logic [SCALE_W-1:0] scale_ff;
   logic [WORD_W-1:0]  limit_ff;
   logic [0:0]         csr_idx;
   logic               csr_wr;
   cmd_type            cmd;
   status_type         status;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_SIGMA_SCALE:     scale_ff <= csr_pwdata[SCALE_W-1:0];
            CSR_VARIATION_LIMIT: limit_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_SIGMA_SCALE:     csr_prdata = WORD_W'(scale_ff);
         CSR_VARIATION_LIMIT: csr_prdata = limit_ff;
         default:             csr_prdata = '0;
      endcase
   end

   scf_ctrl #(.MAX_SAMPLES(MAX_SAMPLES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   scf_dpath #(.MAX_SAMPLES(MAX_SAMPLES), .MIN_FOR_CLIP(MIN_FOR_CLIP)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .pos_x           (req_ch.pos_x),
      .pos_y           (req_ch.pos_y),
      .radiance        (req_ch.radiance),
      .path_depth      (req_ch.path_depth),
      .invalid         (req_ch.invalid),
      .sigma_scale     (scale_ff),
      .variation_limit (limit_ff),
      .rsp             (rsp_ch)
   );
endmodule
`default_nettype wire
